[sv/bfr_pkg.sv]
// Package for the boot frame receiver: controller states, result actions,
// byte codes, register indexes and the command and status structs.
// Depends on nothing.
package bfr_pkg;

   localparam logic [7:0] PREAMBLE_BYTE = 8'hAA;
   localparam logic [7:0] COLON_BYTE = 8'h3A;
   localparam logic [7:0] END_BYTE = 8'h53;
   localparam logic [3:0] COUNT_MAX = 4'd15;
   localparam logic [3:0] COUNT_START = 4'd1;
   localparam logic [3:0] MIN_PREAMBLE_RESET = 4'd4;

   localparam int CSR_DATA_W = 4;

   typedef enum logic {
      REG_MIN_PREAMBLE = 1'b0,
      REG_PROGRAM_PRESENT = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_START = 2'd1,
      ACT_ERASE = 2'd2,
      ACT_RESTART = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_HUNT,
      ST_LEN,
      ST_ALO,
      ST_AHI,
      ST_SUM,
      ST_DATA,
      ST_COLON,
      ST_EMIT_RD,
      ST_EMIT_WR
   } ctl_state_type;

   typedef struct packed {
      logic hunt_reset;
      logic count_inc;
      logic load_len;
      logic load_alo;
      logic load_ahi;
      logic add_sum;
      logic store_data;
      logic set_erased;
      logic set_written;
      logic emit_single;
      action_type action;
      logic word_start;
      logic word_next;
      logic word_load;
   } cmd_type;

   typedef struct packed {
      logic good;
      logic is_preamble;
      logic is_colon;
      logic is_end;
      logic count_ok;
      logic len_zero;
      logic data_done;
      logic sum_next_zero;
      logic present;
      logic page_written;
      logic out_free;
      logic word_last;
   } status_type;

endpackage

[sv/bfr_req_if.sv]
// Request channel of the boot frame receiver: one received byte and its parity bit.
// Depends on nothing.
interface bfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       rx_parity;

   modport source (output valid, output rx_byte, output rx_parity, input ready);
   modport sink (input valid, input rx_byte, input rx_parity, output ready);
endinterface

[sv/bfr_rsp_if.sv]
// Response channel of the boot frame receiver: one flash action per transaction.
// Depends on nothing.
interface bfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [15:0] word_address;
   logic [15:0] word_value;
   logic        last;

   modport source (output valid, output action, output word_address, output word_value,
                   output last, input ready);
   modport sink (input valid, input action, input word_address, input word_value,
                 input last, output ready);
endinterface

[sv/bfr_ctl.sv]
// Controller of the boot frame receiver: frame parsing and page emission sequencing.
// Depends on bfr_pkg; drives the datapath through cmd_type and reads status_type.
module bfr_ctl
   import bfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      logic parse_state;
      logic accept;
      logic do_fail;
      logic do_start;
      logic do_finish;

      parse_state = 1'b0;
      do_fail = 1'b0;
      do_start = 1'b0;
      do_finish = 1'b0;
      cmd = '0;
      cmd.action = ACT_WRITE;
      state_in = state_ff;

      case (state_ff)
         ST_HUNT, ST_LEN, ST_ALO, ST_AHI, ST_SUM, ST_DATA, ST_COLON: begin
            parse_state = 1'b1;
         end
         default: begin
            parse_state = 1'b0;
         end
      endcase

      req_ready = parse_state && status.out_free;
      accept = req_valid && req_ready;

      case (state_ff)
         ST_HUNT: begin
            if (accept) begin
               if (status.good && status.is_preamble) begin
                  cmd.count_inc = 1'b1;
               end else if (status.good && status.is_colon && status.count_ok) begin
                  state_in = ST_LEN;
               end else begin
                  do_start = 1'b1;
               end
            end
         end
         ST_COLON: begin
            if (accept) begin
               if (!status.good || !status.is_colon) begin
                  do_fail = 1'b1;
               end else begin
                  state_in = ST_LEN;
               end
            end
         end
         ST_LEN: begin
            if (accept) begin
               if (!status.good) begin
                  do_fail = 1'b1;
               end else if (status.is_end) begin
                  cmd.emit_single = 1'b1;
                  cmd.action = ACT_START;
                  cmd.hunt_reset = 1'b1;
                  state_in = ST_HUNT;
               end else begin
                  cmd.load_len = 1'b1;
                  state_in = ST_ALO;
               end
            end
         end
         ST_ALO: begin
            if (accept) begin
               if (!status.good) begin
                  do_fail = 1'b1;
               end else begin
                  cmd.load_alo = 1'b1;
                  state_in = ST_AHI;
               end
            end
         end
         ST_AHI: begin
            if (accept) begin
               if (!status.good) begin
                  do_fail = 1'b1;
               end else begin
                  cmd.load_ahi = 1'b1;
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            if (accept) begin
               if (!status.good) begin
                  do_fail = 1'b1;
               end else begin
                  cmd.add_sum = 1'b1;
                  state_in = ST_DATA;
                  do_finish = status.len_zero;
               end
            end
         end
         ST_DATA: begin
            if (accept) begin
               if (!status.good) begin
                  do_fail = 1'b1;
               end else begin
                  cmd.store_data = 1'b1;
                  do_finish = status.data_done;
               end
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            if (status.out_free) begin
               cmd.word_load = 1'b1;
               if (status.word_last) begin
                  state_in = ST_COLON;
               end else begin
                  cmd.word_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_HUNT;
            cmd.hunt_reset = 1'b1;
         end
      endcase

      if (do_finish) begin
         if (status.sum_next_zero) begin
            cmd.word_start = 1'b1;
            cmd.set_written = 1'b1;
            state_in = ST_EMIT_RD;
         end else begin
            do_fail = 1'b1;
         end
      end

      if (do_fail) begin
         if (!status.page_written && status.present) begin
            do_start = 1'b1;
         end else begin
            cmd.emit_single = 1'b1;
            cmd.action = ACT_ERASE;
            cmd.set_erased = 1'b1;
            cmd.hunt_reset = 1'b1;
            state_in = ST_HUNT;
         end
      end

      if (do_start) begin
         cmd.emit_single = 1'b1;
         cmd.action = status.present ? ACT_START : ACT_RESTART;
         cmd.hunt_reset = 1'b1;
         state_in = ST_HUNT;
      end
   end

endmodule

[sv/bfr_dp.sv]
// Datapath of the boot frame receiver: frame registers, page memory, settings
// registers and the response register. Depends on bfr_pkg; commanded by bfr_ctl.
module bfr_dp
   import bfr_pkg::*;
#(
   parameter int PAGE_BYTES = 128
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            rx_byte,
   input  logic                  rx_parity,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_action,
   output logic [15:0]           rsp_word_address,
   output logic [15:0]           rsp_word_value,
   output logic                  rsp_last,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  cmd_type               cmd,
   output status_type            status
);

   localparam int WORDS = PAGE_BYTES / 2;
   localparam int ADDR_W = $clog2(PAGE_BYTES);
   localparam int WIDX_W = $clog2(WORDS);
   localparam logic [7:0] PAGE_LIMIT = 8'(PAGE_BYTES);
   localparam logic [WIDX_W-1:0] WORD_LAST_IDX = WIDX_W'(WORDS - 1);

   logic [3:0]            min_preamble_ff;
   logic                  program_present_ff;
   logic [3:0]            preamble_count_ff;
   logic [7:0]            frame_length_ff;
   logic [15:0]           frame_address_ff;
   logic [7:0]            running_sum_ff;
   logic [7:0]            byte_index_ff;
   logic                  page_written_ff;
   logic                  flash_erased_ff;
   logic [7:0]            page_mem_ff [PAGE_BYTES];
   logic [PAGE_BYTES-1:0] entry_valid_ff;
   logic [WIDX_W-1:0]     word_idx_ff;
   logic [WIDX_W-1:0]     word_idx_in;
   logic [7:0]            rd_lo_ff;
   logic [7:0]            rd_hi_ff;
   logic                  rd_lo_valid_ff;
   logic                  rd_hi_valid_ff;
   logic                  rsp_valid_ff;
   logic [1:0]            rsp_action_ff;
   logic [15:0]           rsp_word_address_ff;
   logic [15:0]           rsp_word_value_ff;
   logic                  rsp_last_ff;

   logic [7:0]        sum_next;
   logic [7:0]        index_next;
   logic              out_free;
   logic              store_en;
   logic [ADDR_W-1:0] rd_lo_addr;
   logic [ADDR_W-1:0] rd_hi_addr;
   logic [7:0]        word_lo;
   logic [7:0]        word_hi;

   assign sum_next = running_sum_ff + rx_byte;
   assign index_next = byte_index_ff + 8'd1;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign store_en = cmd.store_data && (byte_index_ff < PAGE_LIMIT);

   assign status.good = ~^{rx_parity, rx_byte};
   assign status.is_preamble = (rx_byte == PREAMBLE_BYTE);
   assign status.is_colon = (rx_byte == COLON_BYTE);
   assign status.is_end = (rx_byte == END_BYTE);
   assign status.count_ok = (preamble_count_ff > min_preamble_ff);
   assign status.len_zero = (frame_length_ff == 8'd0);
   assign status.data_done = (index_next >= frame_length_ff);
   assign status.sum_next_zero = (sum_next == 8'd0);
   assign status.present = program_present_ff && !flash_erased_ff;
   assign status.page_written = page_written_ff;
   assign status.out_free = out_free;
   assign status.word_last = (word_idx_ff == WORD_LAST_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_preamble_ff <= MIN_PREAMBLE_RESET;
         program_present_ff <= 1'b0;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_MIN_PREAMBLE: begin
               min_preamble_ff <= csr_wdata;
            end
            REG_PROGRAM_PRESENT: begin
               program_present_ff <= csr_wdata[0];
            end
            default: begin
               min_preamble_ff <= min_preamble_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_count_ff <= COUNT_START;
         frame_length_ff <= '0;
         frame_address_ff <= '0;
         running_sum_ff <= '0;
         byte_index_ff <= '0;
         page_written_ff <= 1'b0;
         flash_erased_ff <= 1'b0;
      end else begin
         if (cmd.hunt_reset) begin
            preamble_count_ff <= COUNT_START;
            frame_length_ff <= '0;
            frame_address_ff <= '0;
            running_sum_ff <= '0;
            byte_index_ff <= '0;
            page_written_ff <= 1'b0;
         end else begin
            if (cmd.count_inc && (preamble_count_ff < COUNT_MAX)) begin
               preamble_count_ff <= preamble_count_ff + 4'd1;
            end
            if (cmd.load_len) begin
               frame_length_ff <= rx_byte;
               running_sum_ff <= rx_byte;
               byte_index_ff <= '0;
            end
            if (cmd.load_alo) begin
               frame_address_ff[7:0] <= rx_byte;
            end
            if (cmd.load_ahi) begin
               frame_address_ff[15:8] <= rx_byte;
            end
            if (cmd.load_alo || cmd.load_ahi || cmd.add_sum || cmd.store_data) begin
               running_sum_ff <= sum_next;
            end
            if (cmd.store_data) begin
               byte_index_ff <= index_next;
            end
            if (cmd.set_written) begin
               page_written_ff <= 1'b1;
            end
         end
         if (cmd.set_erased) begin
            flash_erased_ff <= 1'b1;
         end else if (cmd.set_written) begin
            flash_erased_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         page_mem_ff[byte_index_ff[ADDR_W-1:0]] <= rx_byte;
      end
      rd_lo_ff <= page_mem_ff[rd_lo_addr];
      rd_hi_ff <= page_mem_ff[rd_hi_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (store_en) begin
         entry_valid_ff[byte_index_ff[ADDR_W-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_lo_valid_ff <= entry_valid_ff[rd_lo_addr];
      rd_hi_valid_ff <= entry_valid_ff[rd_hi_addr];
   end

   always_comb begin
      word_idx_in = word_idx_ff;
      if (cmd.word_start) begin
         word_idx_in = '0;
      end else if (cmd.word_next) begin
         word_idx_in = WIDX_W'(word_idx_ff + 1'b1);
      end
   end

   assign rd_lo_addr = ADDR_W'({word_idx_in, 1'b0});
   assign rd_hi_addr = ADDR_W'({word_idx_in, 1'b1});
   assign word_lo = rd_lo_valid_ff ? rd_lo_ff : 8'd0;
   assign word_hi = rd_hi_valid_ff ? rd_hi_ff : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_idx_ff <= '0;
      end else begin
         word_idx_ff <= word_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free && (cmd.emit_single || cmd.word_load)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && cmd.emit_single) begin
         rsp_action_ff <= cmd.action;
         rsp_word_address_ff <= '0;
         rsp_word_value_ff <= '0;
         rsp_last_ff <= 1'b1;
      end else if (out_free && cmd.word_load) begin
         rsp_action_ff <= ACT_WRITE;
         rsp_word_address_ff <= frame_address_ff + 16'({word_idx_ff, 1'b0});
         rsp_word_value_ff <= {word_hi, word_lo};
         rsp_last_ff <= status.word_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_action = rsp_action_ff;
   assign rsp_word_address = rsp_word_address_ff;
   assign rsp_word_value = rsp_word_value_ff;
   assign rsp_last = rsp_last_ff;

endmodule

[sv/boot_frame_receiver.sv]
// A received byte that causes at most one response is taken when the
// response register is free or being emptied in that cycle. A frame whose
// checksum comes out right holds off new bytes while the page goes out as
// PAGE_BYTES/2 write-word transactions: the first word is read from the
// two-port page memory into its read registers, then one word per cycle goes
// into the response register while the response side does not stall. Page memory
// entries read as zero until written; reset clears their valid bits at once.
// Depends on bfr_pkg, bfr_req_if, bfr_rsp_if, bfr_ctl and bfr_dp.
module boot_frame_receiver
   import bfr_pkg::*;
#(
   parameter int PAGE_BYTES = 128
)
(
   input  logic                  clock,
   input  logic                  reset,
   bfr_req_if.sink               req_chan,
   bfr_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   bfr_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bfr_dp #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .rx_byte          (req_chan.rx_byte),
      .rx_parity        (req_chan.rx_parity),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_action       (rsp_chan.action),
      .rsp_word_address (rsp_chan.word_address),
      .rsp_word_value   (rsp_chan.word_value),
      .rsp_last         (rsp_chan.last),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .status           (status)
   );

`ifndef SYNTHESIS
   a_no_accept_while_blocked: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("byte taken while the response register was held");

   a_single_is_plain: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.action != ACT_WRITE)) |->
      (rsp_chan.last && (rsp_chan.word_address == 16'd0) && (rsp_chan.word_value == 16'd0)))
      else $error("non-write response carries payload or is not last");

   a_page_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.action == ACT_WRITE) && !rsp_chan.last) |->
      !req_chan.ready)
      else $error("input taken in the middle of a page");

   a_word_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && (rsp_chan.action == ACT_WRITE)
       && !rsp_chan.last) |=> (rsp_chan.action == ACT_WRITE))
      else $error("page emission interrupted by another response");
`endif

endmodule
